// ----- src/video_column_pixel_decoder_defines.svh -----
// Assertion macros shared by the column pixel decoder modules
`ifndef VIDEO_COLUMN_PIXEL_DECODER_DEFINES_SVH
`define VIDEO_COLUMN_PIXEL_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Implication checked on the same edge
`define VCPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Implication checked on the following edge
`define VCPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define VCPD_ASSERT_NOW(label, ante, cons, msg)
`define VCPD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- src/vcpd_pkg.sv -----
// Types, register indexes and colour helpers of the column pixel decoder
package vcpd_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;

   // Register indexes on the configuration channel
   localparam logic [CSR_INDEX_W-1:0] CSR_VIDEO_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_CODE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALT_TWO    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALT_FOUR   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIX_BIAS   = 3'd5;

   typedef enum logic [1:0] {
      MODE_PIXEL  = 2'd0,
      MODE_LPIXEL = 2'd1,
      MODE_CHAR   = 2'd2,
      MODE_ATTR   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    video_mode;
      logic [1:0]  depth_code;
      logic        alt_two_enable;
      logic        alt_four_enable;
      logic [63:0] palette_low;
      logic [4:0]  fix_bias;
   } cfg_type;

   // One pixel on its way to the palette stage
   typedef struct packed {
      logic       direct;    // raw colour byte given as is (eight bits per pixel)
      logic [3:0] pal_index;
      logic [7:0] raw_byte;
      logic       last;
   } pix_type;

   typedef struct packed {
      logic [3:0] red;
      logic [3:0] green;
      logic [3:0] blue;
   } rgb_type;

   // Spread a raw colour byte over three 4-bit channels
   function automatic rgb_type colour_expand(input logic [7:0] s);
      rgb_type    c;
      logic [2:0] r3;
      logic [2:0] g3;
      logic [1:0] b2;
      r3 = {s[0], s[3], s[6]};
      g3 = {s[1], s[4], s[7]};
      b2 = {s[2], s[5]};
      c.red   = {r3, r3[2]};
      c.green = {g3, g3[2]};
      c.blue  = {b2, b2};
      return c;
   endfunction

endpackage

// ----- src/vcpd_if.sv -----
// Channel interfaces: column request, pixel response and register writes
interface vcpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] first_byte;
   logic [7:0] second_byte;
   modport source (output valid, output first_byte, output second_byte, input ready);
   modport sink (input valid, input first_byte, input second_byte, output ready);
endinterface

interface vcpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] red;
   logic [3:0] green;
   logic [3:0] blue;
   logic       last;
   modport source (output valid, output red, output green, output blue, output last,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input last,
                 output ready);
endinterface

interface vcpd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/vcpd_csr.sv -----
// Configuration register file of the column pixel decoder
module vcpd_csr
   import vcpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   vcpd_csr_if.sink          csr_bus,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid && csr_bus.ready;

   // Decode the write; indexes beyond the list leave everything as is
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_bus.index)
            CSR_VIDEO_MODE: cfg_in.video_mode      = mode_type'(csr_bus.data[1:0]);
            CSR_DEPTH_CODE: cfg_in.depth_code      = csr_bus.data[1:0];
            CSR_ALT_TWO:    cfg_in.alt_two_enable  = csr_bus.data[0];
            CSR_ALT_FOUR:   cfg_in.alt_four_enable = csr_bus.data[0];
            CSR_PALETTE:    cfg_in.palette_low     = csr_bus.data;
            CSR_FIX_BIAS:   cfg_in.fix_bias        = csr_bus.data[4:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/vcpd_unpack.sv -----
// Column register and pixel counter: picks the palette index of each pixel
`include "video_column_pixel_decoder_defines.svh"
module vcpd_unpack
   import vcpd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   vcpd_req_if.sink req_bus,
   output logic     pix_valid,
   input  logic     pix_ready,
   output pix_type  pix
);

   logic       busy_ff, busy_in;
   logic [7:0] a_ff, a_in;
   logic [7:0] b_ff, b_in;
   logic [3:0] k_ff, k_in;

   logic       req_fire;
   logic       pix_fire;
   logic       is_last;
   logic [3:0] last_k;
   logic [3:0] per_byte;
   logic [2:0] j;
   logic       byte_sel;
   logic [7:0] x;
   logic [7:0] xm;
   logic       base_two;
   logic       base_four;
   logic       attr_bit;

   // Pixel count of the column, less one
   always_comb begin
      case (cfg.video_mode)
         MODE_PIXEL:  last_k = 4'((5'd16 >> cfg.depth_code) - 5'd1);
         MODE_LPIXEL: last_k = 4'((5'd8 >> cfg.depth_code) - 5'd1);
         MODE_CHAR:   last_k = 4'((5'd8 >> cfg.depth_code) - 5'd1);
         default:     last_k = 4'd7;
      endcase
   end

   // Select the source byte and the pixel position within it
   always_comb begin
      per_byte = 4'd8 >> cfg.depth_code;
      j        = k_ff[2:0] & 3'(per_byte - 4'd1);
      byte_sel = (cfg.video_mode == MODE_PIXEL) && ((k_ff & per_byte) != 4'd0);
      x        = (cfg.video_mode == MODE_CHAR || byte_sel) ? b_ff : a_ff;
      xm       = x;
      base_two  = 1'b0;
      base_four = 1'b0;
      if (cfg.depth_code == 2'd0) begin
         if (cfg.video_mode == MODE_CHAR) begin
            base_two  = cfg.alt_two_enable && a_ff[7];
            base_four = cfg.alt_four_enable && a_ff[6];
         end else begin
            // alternate palette from the unmasked byte, then mask it
            base_two  = cfg.alt_two_enable && x[7];
            base_four = cfg.alt_four_enable && x[0];
            if (cfg.alt_two_enable) xm[0] = 1'b0;
            if (cfg.alt_four_enable) xm[7] = 1'b0;
         end
      end
      attr_bit = b_ff[~k_ff[2:0]];
   end

   // Form the palette index at the current depth
   always_comb begin
      pix.direct   = 1'b0;
      pix.raw_byte = xm;
      pix.last     = is_last;
      if (cfg.video_mode == MODE_ATTR) begin
         pix.pal_index = attr_bit ? a_ff[3:0] : a_ff[7:4];
      end else begin
         case (cfg.depth_code)
            2'd0: pix.pal_index = {1'b0, base_four, base_two, xm[~j]};
            2'd1: pix.pal_index = {2'b00, xm[{1'b0, ~j[1:0]}], xm[{1'b1, ~j[1:0]}]};
            2'd2: pix.pal_index = j[0] ? {xm[0], xm[4], xm[2], xm[6]}
                                       : {xm[1], xm[5], xm[3], xm[7]};
            default: begin
               pix.pal_index = 4'd0;
               pix.direct    = 1'b1;
            end
         endcase
      end
   end

   assign is_last       = (k_ff == last_k);
   assign pix_valid     = busy_ff;
   assign pix_fire      = busy_ff && pix_ready;
   assign req_bus.ready = !busy_ff || (pix_ready && is_last);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Load a new request or advance through the pixels of the current one
   always_comb begin
      busy_in = busy_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      if (req_fire) begin
         busy_in = 1'b1;
         a_in    = req_bus.first_byte;
         b_in    = req_bus.second_byte;
         k_in    = 4'd0;
      end else if (pix_fire) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            k_in = k_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   `VCPD_ASSERT_NEXT(a_load_restarts, req_fire, busy_ff && k_ff == 4'd0, "request load did not restart the pixel count")
   `VCPD_ASSERT_NEXT(a_stall_holds, busy_ff && !pix_ready && !req_fire, $stable(k_ff) && busy_ff, "pixel count moved while stalled")
   `VCPD_ASSERT_NEXT(a_last_frees, pix_fire && is_last && !req_fire, !busy_ff, "column not released after its final pixel")
   `VCPD_ASSERT_NOW(a_count_range, busy_ff, k_ff <= last_k, "pixel count beyond the end of the column")

endmodule

// ----- src/vcpd_palette.sv -----
// Palette lookup, colour expansion and the response register
`include "video_column_pixel_decoder_defines.svh"
module vcpd_palette
   import vcpd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      pix_valid,
   output logic      pix_ready,
   input  pix_type   pix,
   vcpd_rsp_if.source rsp_bus
);

   logic       out_valid_ff, out_valid_in;
   rgb_type    rgb_ff, rgb_in;
   logic       last_ff, last_in;
   logic [7:0] raw;
   logic       load;

   // Look up the raw colour byte
   always_comb begin
      if (pix.direct) begin
         raw = pix.raw_byte;
      end else if (pix.pal_index[3]) begin
         raw = {cfg.fix_bias, pix.pal_index[2:0]};
      end else begin
         raw = cfg.palette_low[{pix.pal_index[2:0], 3'b000} +: 8];
      end
   end

   assign pix_ready = !out_valid_ff || rsp_bus.ready;
   assign load      = pix_valid && pix_ready;

   // Refill the response register whenever it drains
   always_comb begin
      out_valid_in = out_valid_ff;
      rgb_in       = rgb_ff;
      last_in      = last_ff;
      if (pix_ready) begin
         out_valid_in = pix_valid;
      end
      if (load) begin
         rgb_in  = colour_expand(raw);
         last_in = pix.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rgb_ff  <= rgb_in;
      last_ff <= last_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.red   = rgb_ff.red;
   assign rsp_bus.green = rgb_ff.green;
   assign rsp_bus.blue  = rgb_ff.blue;
   assign rsp_bus.last  = last_ff;

   `VCPD_ASSERT_NEXT(a_load_shows, load, out_valid_ff, "loaded pixel not presented")
   `VCPD_ASSERT_NEXT(a_held_kept, out_valid_ff && !rsp_bus.ready, out_valid_ff && $stable(last_ff), "waiting pixel lost")
   `VCPD_ASSERT_NOW(a_direct_mode, pix_valid && pix.direct, cfg.depth_code == 2'd3 && cfg.video_mode != MODE_ATTR, "direct colour outside eight-bit depth")

endmodule

// ----- src/video_column_pixel_decoder.sv -----
// Top level of the column pixel decoder
// A request's first pixel passes the column register, then the response register.
// Throughput: one pixel per cycle unless the response stalls; a column has 1 to 16 pixels;
// the single pixel path from the column register to the response register sets this.
// The next request is taken on the edge that moves a column's final pixel to the response.
// Reset (synchronous, active high) empties the pipeline and zeroes the configuration.
module video_column_pixel_decoder
   import vcpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   vcpd_req_if.sink   req_bus,
   vcpd_rsp_if.source rsp_bus,
   vcpd_csr_if.sink   csr_bus
);

   cfg_type cfg;
   logic    pix_valid;
   logic    pix_ready;
   pix_type pix;

   vcpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   vcpd_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_bus   (req_bus),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix       (pix)
   );

   vcpd_palette u_palette (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix       (pix),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ----- verif/video_column_pixel_decoder_tb.sv -----
// Self-checking testbench of the column pixel decoder: directed and random columns
`timescale 1ns / 100ps

module video_column_pixel_decoder_tb
   import vcpd_pkg::*;
;

   // Depth codes (bits per pixel = 1 << code)
   localparam logic [1:0] DEPTH_1BPP = 2'd0;
   localparam logic [1:0] DEPTH_2BPP = 2'd1;
   localparam logic [1:0] DEPTH_4BPP = 2'd2;
   localparam logic [1:0] DEPTH_8BPP = 2'd3;

   // Indexes past the register list; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [3:0] red;
      logic [3:0] green;
      logic [3:0] blue;
      logic       last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset;

   vcpd_req_if req_bus ();
   vcpd_rsp_if rsp_bus ();
   vcpd_csr_if csr_bus ();

   video_column_pixel_decoder DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow registers, expected pixels and scratch list of raw colour bytes
   cfg_type    shadow_cfg;
   pixel_type  pending_pixels[$];
   logic [7:0] column_bytes[$];
   int         mismatches;

   // Idling controls
   bit req_gap_on;
   bit rsp_stall_on;
   bit pixel_taken;
   int rsp_hold;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] palette_byte(input logic [3:0] idx);
      if (!idx[3]) begin
         return shadow_cfg.palette_low[8*idx[2:0] +: 8];
      end
      return {shadow_cfg.fix_bias, idx[2:0]};
   endfunction

   // Unpack one byte at the current depth; base only matters at one bit
   function automatic void unpack_at_depth(input logic [7:0] x, input logic [3:0] base);
      case (shadow_cfg.depth_code)
         DEPTH_1BPP: begin
            for (int i = 7; i >= 0; i--)
               column_bytes.push_back(palette_byte(base + x[i]));
         end
         DEPTH_2BPP: begin
            for (int i = 0; i < 4; i++)
               column_bytes.push_back(palette_byte({2'b00, x[3-i], x[7-i]}));
         end
         DEPTH_4BPP: begin
            column_bytes.push_back(palette_byte({x[1], x[5], x[3], x[7]}));
            column_bytes.push_back(palette_byte({x[0], x[4], x[2], x[6]}));
         end
         default: begin
            column_bytes.push_back(x);
         end
      endcase
   endfunction

   // Pixel-mode byte: alternate base from the unmasked byte, then mask as written
   function automatic void unpack_pixel_byte(input logic [7:0] x);
      logic [3:0] base;
      logic [7:0] bits;
      base = 4'd0;
      bits = x;
      if (shadow_cfg.depth_code == DEPTH_1BPP) begin
         if (shadow_cfg.alt_two_enable && x[7]) base = base + 4'd2;
         if (shadow_cfg.alt_four_enable && x[0]) base = base + 4'd4;
         if (shadow_cfg.alt_two_enable) bits[0] = 1'b0;
         if (shadow_cfg.alt_four_enable) bits[7] = 1'b0;
      end
      unpack_at_depth(bits, base);
   endfunction

   // Work out every pixel of one column and queue them in display order
   function automatic void decode_column(input logic [7:0] first, input logic [7:0] second);
      logic [3:0] base;
      logic [7:0] s;
      pixel_type  px;
      column_bytes.delete();
      case (shadow_cfg.video_mode)
         MODE_PIXEL: begin
            unpack_pixel_byte(first);
            unpack_pixel_byte(second);
         end
         MODE_LPIXEL: begin
            unpack_pixel_byte(first);
         end
         MODE_CHAR: begin
            base = 4'd0;
            if (shadow_cfg.alt_two_enable && first[7]) base = base + 4'd2;
            if (shadow_cfg.alt_four_enable && first[6]) base = base + 4'd4;
            unpack_at_depth(second, base);
         end
         default: begin
            for (int k = 7; k >= 0; k--)
               column_bytes.push_back(palette_byte(second[k] ? first[3:0] : first[7:4]));
         end
      endcase
      foreach (column_bytes[k]) begin
         s = column_bytes[k];
         px.red   = {s[0], s[3], s[6], s[0]};
         px.green = {s[1], s[4], s[7], s[1]};
         px.blue  = {s[2], s[5], s[2], s[5]};
         px.last  = (k == column_bytes.size() - 1);
         pending_pixels.push_back(px);
      end
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_VIDEO_MODE: shadow_cfg.video_mode      = mode_type'(data[1:0]);
         CSR_DEPTH_CODE: shadow_cfg.depth_code      = data[1:0];
         CSR_ALT_TWO:    shadow_cfg.alt_two_enable  = data[0];
         CSR_ALT_FOUR:   shadow_cfg.alt_four_enable = data[0];
         CSR_PALETTE:    shadow_cfg.palette_low     = data;
         CSR_FIX_BIAS:   shadow_cfg.fix_bias        = data[4:0];
         default: ;
      endcase
   endfunction

   function automatic void log_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
   endfunction

   // ---------------------------------------------------------------- drivers

   // Hold the response side off for a drawn number of cycles after each pixel
   always @(negedge clock) begin
      if (pixel_taken) begin
         pixel_taken = 1'b0;
         rsp_hold = rsp_stall_on ? $urandom_range(0, 19) : 0;
      end
      if (rsp_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare each accepted pixel with the oldest expectation
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         pixel_taken = 1'b1;
         if (pending_pixels.size() == 0) begin
            log_mismatch($sformatf("%0t: unexpected pixel r=%h g=%h b=%h last=%b",
                                   $realtime, rsp_bus.red, rsp_bus.green, rsp_bus.blue,
                                   rsp_bus.last));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_bus.red !== want.red || rsp_bus.green !== want.green ||
                rsp_bus.blue !== want.blue || rsp_bus.last !== want.last)
               log_mismatch($sformatf(
                  {"%0t: pixel mismatch: expected r=%h g=%h b=%h last=%b, ",
                   "got r=%h g=%h b=%h last=%b"},
                  $realtime, want.red, want.green, want.blue, want.last,
                  rsp_bus.red, rsp_bus.green, rsp_bus.blue, rsp_bus.last));
         end
      end
   end

   // Send one column request after a drawn gap; queue its pixels once accepted
   task automatic send_column(input logic [7:0] first, input logic [7:0] second);
      int gap;
      gap = req_gap_on ? $urandom_range(0, 19) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.first_byte  <= first;
      req_bus.second_byte <= second;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      decode_column(first, second);
   endtask

   // Drop the request and hold until every queued pixel has come back
   task automatic wait_for_pixels();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      apply_reg(idx, data);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic write_all_regs(input logic [CSR_DATA_W-1:0] mode,
                                 input logic [CSR_DATA_W-1:0] depth,
                                 input logic [CSR_DATA_W-1:0] alt_two,
                                 input logic [CSR_DATA_W-1:0] alt_four,
                                 input logic [CSR_DATA_W-1:0] palette,
                                 input logic [CSR_DATA_W-1:0] bias);
      write_reg(CSR_VIDEO_MODE, mode);
      write_reg(CSR_DEPTH_CODE, depth);
      write_reg(CSR_ALT_TWO, alt_two);
      write_reg(CSR_ALT_FOUR, alt_four);
      write_reg(CSR_PALETTE, palette);
      write_reg(CSR_FIX_BIAS, bias);
   endtask

   // ---------------------------------------------------------------- tests

   // Registers straight out of reset: pixel mode, one bit, black palette
   task automatic test_reset_state();
      req_gap_on   = 1'b1;
      rsp_stall_on = 1'b1;
      send_column(8'h00, 8'hFF);
      send_column(8'hFF, 8'h00);
      wait_for_pixels();
   endtask

   // Every mode at every depth with a distinctive palette and bias
   task automatic test_modes_and_depths();
      write_all_regs(64'(MODE_PIXEL), 64'(DEPTH_1BPP), 64'd0, 64'd0,
                     64'hFF_C0_38_07_A5_5A_01_80, 64'h15);
      for (int m = 0; m < 4; m++) begin
         for (int d = 0; d < 4; d++) begin
            wait_for_pixels();
            write_reg(CSR_VIDEO_MODE, 64'(m));
            write_reg(CSR_DEPTH_CODE, 64'(d));
            send_column((d % 2) ? 8'hA5 : 8'h3C, (d % 2) ? 8'h3C : 8'hA5);
         end
      end
      wait_for_pixels();
   endtask

   // Alternate palette bases in one-bit pixel, lpixel and character modes
   task automatic test_alternate_palettes();
      write_all_regs(64'(MODE_PIXEL), 64'(DEPTH_1BPP), 64'd1, 64'd1,
                     64'h01_02_04_08_10_20_40_80, 64'h0A);
      send_column(8'h81, 8'h7E);
      wait_for_pixels();
      write_reg(CSR_VIDEO_MODE, 64'(MODE_LPIXEL));
      write_reg(CSR_ALT_FOUR, 64'd0);
      send_column(8'hFF, 8'h00);
      wait_for_pixels();
      write_reg(CSR_VIDEO_MODE, 64'(MODE_CHAR));
      write_reg(CSR_ALT_FOUR, 64'd1);
      send_column(8'hC0, 8'hA5);
      send_column(8'h40, 8'h0F);
      wait_for_pixels();
   endtask

   // Full palette and bias, attribute mode, oversized values and spare indexes
   task automatic test_extreme_registers();
      write_all_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_SPARE_LO, 64'h0);
      write_reg(CSR_SPARE_HI, 64'h0);
      send_column(8'hF8, 8'hA5);
      wait_for_pixels();
      write_reg(CSR_VIDEO_MODE, 64'hFFFF_FFFF_FFFF_FFFC);
      write_reg(CSR_FIX_BIAS, 64'hFFFF_FFFF_FFFF_FFE0);
      send_column(8'h7E, 8'h81);
      wait_for_pixels();
   endtask

   // Random columns over several register settings and idling patterns
   task automatic test_random_columns();
      for (int phase = 0; phase < 8; phase++) begin
         wait_for_pixels();
         if (phase == 0) begin
            write_all_regs(64'(MODE_ATTR), 64'(DEPTH_8BPP), 64'd1, 64'd1,
                           64'hFFFF_FFFF_FFFF_FFFF, 64'h1F);
         end else if (phase == 1) begin
            write_all_regs(64'(MODE_PIXEL), 64'(DEPTH_1BPP), 64'd0, 64'd0, 64'h0, 64'h00);
         end else begin
            write_all_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
            if (phase == 2) write_reg(CSR_SPARE_LO, {$urandom, $urandom});
         end
         req_gap_on   = (phase % 3 != 0);
         rsp_stall_on = (phase % 4 != 1);
         for (int item = 0; item < 17; item++) begin
            // let the block run dry once in the middle of a phase
            if (phase == 4 && item == 10) wait_for_pixels();
            send_column(8'($urandom), 8'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.first_byte  = 8'h00;
      req_bus.second_byte = 8'h00;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_VIDEO_MODE;
      csr_bus.data        = '0;
      shadow_cfg          = '0;
      mismatches          = 0;
      pixel_taken         = 1'b0;
      rsp_hold            = 0;
      req_gap_on          = 1'b0;
      rsp_stall_on        = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_modes_and_depths();
      test_alternate_palettes();
      test_extreme_registers();
      test_random_columns();

      wait_for_pixels();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
